// ===== design/ppmp_pkg.sv =====
// Shared types and constants for the plain-text PPM stream parser.
// Used by ppmp_parse_core, ppmp_out_fifo and ascii_ppm_stream_parser.
// No dependencies.
`default_nettype none

package ppmp_pkg;

  localparam int NumBits   = 16;
  localparam int HdrW      = 16;
  localparam int FieldW    = 16;
  localparam int CntW      = 34;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindHeader = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;
  localparam logic [1:0] KindAccept = 2'd3;

  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChP       = 8'h50;
  localparam logic [7:0] ChThree   = 8'h33;

  typedef enum logic [4:0] {
    PhMagic = 5'b00001,
    PhSize  = 5'b00010,
    PhMaxv  = 5'b00100,
    PhPix   = 5'b01000,
    PhErr   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [FieldW-1:0] sample;
    logic [FieldW-1:0] img_width;
    logic [FieldW-1:0] img_height;
    logic [FieldW-1:0] max_level;
    logic              final_item;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// ===== design/ppmp_parse_core.sv =====
// Parser state and per-byte result logic for the PPM stream parser.
// Depends on ppmp_pkg; fed from the input register of the top level.
`default_nettype none

module ppmp_parse_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire  [7:0]           ch_i,
  input  wire                  eof_i,
  output ppmp_pkg::push_t      push_o
);
  import ppmp_pkg::*;

  phase_e               phase_q, phase_d;
  logic [1:0]           magic_pos_q, magic_pos_d;
  logic                 magic_bad_q, magic_bad_d;
  logic                 line_start_q, line_start_d;
  logic                 in_comment_q, in_comment_d;
  logic                 prev_space_q, prev_space_d;
  logic [1:0]           token_idx_q, token_idx_d;
  logic [HdrW-1:0]      width_q, width_d;
  logic [HdrW-1:0]      height_q, height_d;
  logic [HdrW-1:0]      maxval_q, maxval_d;
  logic [NumBits-1:0]   sample_q, sample_d;
  logic                 in_number_q, in_number_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      expect_q, expect_d;

  logic                 nl, is_space, digit;
  logic [3:0]           dval;
  logic [HdrW-1:0]      hdr_sel;
  logic [HdrW+3:0]      hdr_v;
  logic                 hdr_ovf;
  logic [NumBits+3:0]   smp_v;
  logic                 smp_ovf;
  logic [CntW-1:0]      cnt_inc, cnt_final;
  logic [2*HdrW-1:0]    area;
  logic [1:0]           limit;
  result_t              base;
  push_t                push;

  always_comb begin
    nl       = (ch_i == ChNewline);
    is_space = (ch_i == ChSpace);
    digit    = (ch_i >= ChZero) && (ch_i <= ChNine);
    dval     = 4'(ch_i - ChZero);

    if (phase_q == PhMaxv) begin
      hdr_sel = maxval_q;
    end else if (token_idx_q == 2'd0) begin
      hdr_sel = width_q;
    end else begin
      hdr_sel = height_q;
    end
    hdr_v   = ({4'd0, hdr_sel} << 3) + ({4'd0, hdr_sel} << 1) + (HdrW+4)'(dval);
    hdr_ovf = |hdr_v[HdrW+3:HdrW];

    smp_v   = ({4'd0, sample_q} << 3) + ({4'd0, sample_q} << 1) + (NumBits+4)'(dval);
    smp_ovf = |smp_v[NumBits+3:NumBits];

    cnt_inc   = (count_q == CntMax) ? count_q : count_q + CntW'(1);
    cnt_final = in_number_q ? cnt_inc : count_q;
    area      = width_q * height_q;
    limit     = (phase_q == PhSize) ? 2'd2 : 2'd1;

    base.kind       = KindError;
    base.sample     = '0;
    base.img_width  = FieldW'(width_q);
    base.img_height = FieldW'(height_q);
    base.max_level  = FieldW'(maxval_q);
    base.final_item = 1'b1;
  end

  always_comb begin
    phase_d      = phase_q;
    magic_pos_d  = magic_pos_q;
    magic_bad_d  = magic_bad_q;
    line_start_d = line_start_q;
    in_comment_d = in_comment_q;
    prev_space_d = prev_space_q;
    token_idx_d  = token_idx_q;
    width_d      = width_q;
    height_d     = height_q;
    maxval_d     = maxval_q;
    sample_d     = sample_q;
    in_number_d  = in_number_q;
    count_d      = count_q;
    expect_d     = expect_q;
    push.num     = 2'd0;
    push.r0      = base;
    push.r1      = base;

    if (!in_valid_i) begin
      push.num = 2'd0;
    end else if (eof_i) begin
      if (phase_q == PhPix) begin
        if (in_number_q) begin
          push.num           = 2'd2;
          push.r0.kind       = KindSample;
          push.r0.sample     = FieldW'(sample_q);
          push.r0.final_item = 1'b0;
          push.r1.kind       = (cnt_final == expect_q) ? KindAccept : KindError;
        end else begin
          push.num     = 2'd1;
          push.r0.kind = (cnt_final == expect_q) ? KindAccept : KindError;
        end
      end else if (phase_q != PhErr) begin
        push.num = 2'd1;
      end
      phase_d      = PhMagic;
      magic_pos_d  = '0;
      magic_bad_d  = 1'b0;
      line_start_d = 1'b1;
      in_comment_d = 1'b0;
      prev_space_d = 1'b0;
      token_idx_d  = '0;
      width_d      = '0;
      height_d     = '0;
      maxval_d     = '0;
      sample_d     = '0;
      in_number_d  = 1'b0;
      count_d      = '0;
      expect_d     = '0;
    end else begin
      case (phase_q)
        PhMagic: begin
          if (nl) begin
            if (magic_pos_q == 2'd2 && !magic_bad_q) begin
              phase_d      = PhSize;
              line_start_d = 1'b1;
              prev_space_d = 1'b0;
            end else begin
              phase_d  = PhErr;
              push.num = 2'd1;
            end
          end else if (magic_pos_q >= 2'd2) begin
            magic_bad_d = 1'b1;
          end else begin
            if (ch_i != ((magic_pos_q != 2'd0) ? ChThree : ChP)) begin
              magic_bad_d = 1'b1;
            end
            magic_pos_d = magic_pos_q + 2'd1;
          end
        end
        PhSize, PhMaxv: begin
          if (in_comment_q) begin
            if (nl) begin
              in_comment_d = 1'b0;
              line_start_d = 1'b1;
            end
          end else if (phase_q == PhSize && line_start_q && ch_i == ChHash) begin
            in_comment_d = 1'b1;
            line_start_d = 1'b0;
          end else if (nl) begin
            if (phase_q == PhSize) begin
              if (width_q == '0 || height_q == '0) begin
                phase_d  = PhErr;
                push.num = 2'd1;
              end else begin
                phase_d = PhMaxv;
              end
            end else begin
              phase_d      = PhPix;
              expect_d     = {1'b0, area, 1'b0} + {2'b00, area};
              push.num     = 2'd1;
              push.r0.kind = KindHeader;
            end
            token_idx_d  = '0;
            line_start_d = 1'b1;
            prev_space_d = 1'b0;
          end else if (token_idx_q >= limit) begin
            phase_d  = PhErr;
            push.num = 2'd1;
          end else begin
            if (digit) begin
              if (hdr_ovf) begin
                phase_d  = PhErr;
                push.num = 2'd1;
              end else if (phase_q == PhMaxv) begin
                maxval_d = hdr_v[HdrW-1:0];
              end else if (token_idx_q == 2'd0) begin
                width_d = hdr_v[HdrW-1:0];
              end else begin
                height_d = hdr_v[HdrW-1:0];
              end
            end else if (is_space && !line_start_q && !prev_space_q) begin
              token_idx_d = token_idx_q + 2'd1;
            end
            prev_space_d = is_space;
            line_start_d = 1'b0;
          end
        end
        PhPix: begin
          if (nl || is_space) begin
            if (in_number_q) begin
              push.num       = 2'd1;
              push.r0.kind   = KindSample;
              push.r0.sample = FieldW'(sample_q);
              count_d        = cnt_inc;
              in_number_d    = 1'b0;
              sample_d       = '0;
            end
          end else if (digit) begin
            if (!in_number_q) begin
              in_number_d = 1'b1;
              sample_d    = NumBits'(dval);
            end else if (smp_ovf) begin
              phase_d  = PhErr;
              push.num = 2'd1;
            end else begin
              sample_d = smp_v[NumBits-1:0];
            end
          end else begin
            phase_d  = PhErr;
            push.num = 2'd1;
          end
        end
        PhErr: begin
          push.num = 2'd0;
        end
        default: begin
          phase_d = PhErr;
        end
      endcase
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhMagic;
      magic_pos_q  <= '0;
      magic_bad_q  <= 1'b0;
      line_start_q <= 1'b1;
      in_comment_q <= 1'b0;
      prev_space_q <= 1'b0;
      token_idx_q  <= '0;
      width_q      <= '0;
      height_q     <= '0;
      maxval_q     <= '0;
      sample_q     <= '0;
      in_number_q  <= 1'b0;
      count_q      <= '0;
      expect_q     <= '0;
    end else begin
      phase_q      <= phase_d;
      magic_pos_q  <= magic_pos_d;
      magic_bad_q  <= magic_bad_d;
      line_start_q <= line_start_d;
      in_comment_q <= in_comment_d;
      prev_space_q <= prev_space_d;
      token_idx_q  <= token_idx_d;
      width_q      <= width_d;
      height_q     <= height_d;
      maxval_q     <= maxval_d;
      sample_q     <= sample_d;
      in_number_q  <= in_number_d;
      count_q      <= count_d;
      expect_q     <= expect_d;
    end
  end

  // End of file always rearms the parser for the next file.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && eof_i) |=> (phase_q == PhMagic))
    else $error("parser not rearmed after end of file");

  // In the error phase only end of file may produce anything.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !eof_i && phase_q == PhErr) |-> (push.num == 2'd0))
    else $error("result produced while in error phase");

  // Two results come only from end of file with an open sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.num == 2'd2) |-> (eof_i && in_number_q && phase_q == PhPix))
    else $error("unexpected double result");

  // End of file in the pixel phase always reports the verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && eof_i && phase_q == PhPix) |-> (push.num != 2'd0))
    else $error("missing verdict at end of file");

endmodule

`default_nettype wire

// ===== design/ppmp_out_fifo.sv =====
// Result queue of the PPM stream parser; takes up to two results per cycle.
// Depends on ppmp_pkg.
`default_nettype none

module ppmp_out_fifo (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  ppmp_pkg::push_t                 push_i,
  input  wire                             pop_i,
  output ppmp_pkg::result_t               head_o,
  output logic                            valid_o,
  output logic [ppmp_pkg::FifoCntW-1:0]   count_o
);
  import ppmp_pkg::*;

  result_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d;
  logic                  pop;

  always_comb begin
    pop      = pop_i && (count_q != '0);
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop);
    count_d  = count_q + FifoCntW'(push_i.num) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + FifoPtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

  // The queue must never be pushed past its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((FifoCntW+1)'(count_q) + (FifoCntW+1)'(push_i.num)) <=
    ((FifoCntW+1)'(FifoDepth) + (FifoCntW+1)'(pop)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== design/ascii_ppm_stream_parser.sv =====
// Top level of the plain-text PPM stream parser: input register, parser core
// and result queue. Depends on ppmp_pkg, ppmp_parse_core and ppmp_out_fifo.
// A byte's results reach the master side via the input register and the
// result queue. Throughput: one byte per cycle; the parser core updates
// its state in the cycle after the input register, and the four-entry
// result queue drops tready when it could not take two more results.
// Reset clears all parser state and empties the result queue at once.
`default_nettype none

module ascii_ppm_stream_parser (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [7:0]   s_axis_tdata_i,   // [7:0] ch
  input  wire          s_axis_tlast_i,   // end_of_file
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,   // [15:0] sample, [31:16] img_width,
                                         // [47:32] img_height, [63:48] max_level
  output logic [1:0]   m_axis_tuser_o,   // [1:0] kind
  output logic         m_axis_tlast_o    // final_item
);
  import ppmp_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           ch_q;
  logic                 eof_q;
  logic                 s_fire;
  push_t                push;
  result_t              head;
  logic [FifoCntW-1:0]  fifo_count;

  // A request is taken only while the queue can absorb two results next cycle.
  assign s_axis_tready_o = ((FifoCntW+1)'(fifo_count) + (FifoCntW+1)'(push.num))
                           <= (FifoCntW+1)'(FifoDepth - 2);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= s_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ch_q  <= s_axis_tdata_i;
      eof_q <= s_axis_tlast_i;
    end
  end

  ppmp_parse_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .ch_i       (ch_q),
    .eof_i      (eof_q),
    .push_o     (push)
  );

  ppmp_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready_i),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .count_o (fifo_count)
  );

  assign m_axis_tdata_o = {head.max_level, head.img_height, head.img_width, head.sample};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.final_item;

endmodule

`default_nettype wire

// ===== dv/ppm_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the plain-text PPM stream parser: it watches both stream
// channels, keeps its own model of the parser and compares every result.
// Depends on ppmp_pkg for the result layout, the kind codes and the phases.

module ppm_result_checker (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_tvalid_i,
  input  wire          s_tready_i,
  input  wire  [7:0]   s_tdata_i,
  input  wire          s_tlast_i,
  input  wire          m_tvalid_i,
  input  wire          m_tready_i,
  input  wire  [63:0]  m_tdata_i,
  input  wire  [1:0]   m_tuser_i,
  input  wire          m_tlast_i,
  output int unsigned  mismatches_o,
  output int unsigned  pending_o,
  output int unsigned  checked_o
);

  import ppmp_pkg::*;

  localparam longint HdrMax    = 65535;
  localparam longint SampleMax = (longint'(1) << NumBits) - 1;

  phase_e              parse_phase;
  logic [1:0]          magic_pos;
  logic                magic_bad;
  logic                line_start;
  logic                in_comment;
  logic                prev_space;
  logic [1:0]          token_idx;
  logic [HdrW-1:0]     width_acc;
  logic [HdrW-1:0]     height_acc;
  logic [HdrW-1:0]     maxval_acc;
  logic [NumBits-1:0]  sample_acc;
  logic                in_number;
  logic [CntW-1:0]     samples_seen;
  logic [CntW-1:0]     samples_due;

  result_t     step_results[$];
  result_t     results_due[$];
  int unsigned n_mismatch = 0;
  int unsigned n_checked  = 0;
  int unsigned n_pending  = 0;

  assign mismatches_o = n_mismatch;
  assign pending_o    = n_pending;
  assign checked_o    = n_checked;

  function automatic void clear_state();
    parse_phase  = PhMagic;
    magic_pos    = '0;
    magic_bad    = 1'b0;
    line_start   = 1'b1;
    in_comment   = 1'b0;
    prev_space   = 1'b0;
    token_idx    = '0;
    width_acc    = '0;
    height_acc   = '0;
    maxval_acc   = '0;
    sample_acc   = '0;
    in_number    = 1'b0;
    samples_seen = '0;
    samples_due  = '0;
  endfunction

  function automatic void emit_result(logic [1:0] kind, logic [FieldW-1:0] smp);
    result_t r;
    r.kind       = kind;
    r.sample     = smp;
    r.img_width  = width_acc;
    r.img_height = height_acc;
    r.max_level  = maxval_acc;
    r.final_item = 1'b0;
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void raise_error();
    parse_phase = PhErr;
    emit_result(KindError, '0);
  endfunction

  function automatic void close_sample();
    if (in_number) begin
      emit_result(KindSample, FieldW'(sample_acc));
      if (samples_seen != CntMax) samples_seen = samples_seen + 1'b1;
      in_number  = 1'b0;
      sample_acc = '0;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] ch, logic eof);
    logic            nl;
    logic            is_dig;
    logic [1:0]      tok_lim;
    logic [HdrW-1:0] cur;
    longint          wide;
    result_t         r;
    int              n;
    step_results.delete();
    nl     = (ch == ChNewline);
    is_dig = (ch >= ChZero) && (ch <= ChNine);
    if (eof) begin
      if (parse_phase == PhPix) begin
        close_sample();
        emit_result((samples_seen == samples_due) ? KindAccept : KindError, '0);
      end else if (parse_phase != PhErr) begin
        emit_result(KindError, '0);
      end
      clear_state();
    end else begin
      case (parse_phase)
        PhMagic: begin
          if (nl) begin
            if (magic_pos == 2'd2 && !magic_bad) begin
              parse_phase = PhSize;
              line_start  = 1'b1;
              prev_space  = 1'b0;
            end else begin
              raise_error();
            end
          end else if (magic_pos >= 2'd2) begin
            magic_bad = 1'b1;
          end else begin
            if (ch != ((magic_pos != 2'd0) ? ChThree : ChP)) magic_bad = 1'b1;
            magic_pos = magic_pos + 1'b1;
          end
        end
        PhSize, PhMaxv: begin
          tok_lim = (parse_phase == PhSize) ? 2'd2 : 2'd1;
          if (in_comment) begin
            if (nl) begin
              in_comment = 1'b0;
              line_start = 1'b1;
            end
          end else if (parse_phase == PhSize && line_start && ch == ChHash) begin
            in_comment = 1'b1;
            line_start = 1'b0;
          end else if (nl) begin
            if (parse_phase == PhSize) begin
              if (width_acc == '0 || height_acc == '0) raise_error();
              else parse_phase = PhMaxv;
            end else begin
              parse_phase = PhPix;
              samples_due = CntW'(width_acc) * CntW'(height_acc) * CntW'(3);
              emit_result(KindHeader, '0);
            end
            token_idx  = '0;
            line_start = 1'b1;
            prev_space = 1'b0;
          end else if (token_idx >= tok_lim) begin
            raise_error();
          end else begin
            if (is_dig) begin
              if (parse_phase == PhMaxv) cur = maxval_acc;
              else if (token_idx == 2'd0) cur = width_acc;
              else cur = height_acc;
              wide = longint'(cur) * 10 + longint'(ch - ChZero);
              if (wide > HdrMax) begin
                raise_error();
              end else if (parse_phase == PhMaxv) begin
                maxval_acc = HdrW'(wide);
              end else if (token_idx == 2'd0) begin
                width_acc = HdrW'(wide);
              end else begin
                height_acc = HdrW'(wide);
              end
            end else if (ch == ChSpace && !line_start && !prev_space) begin
              token_idx = token_idx + 1'b1;
            end
            prev_space = (ch == ChSpace);
            line_start = 1'b0;
          end
        end
        PhPix: begin
          if (nl || ch == ChSpace) begin
            close_sample();
          end else if (is_dig) begin
            if (!in_number) begin
              in_number  = 1'b1;
              sample_acc = NumBits'(ch - ChZero);
            end else begin
              wide = longint'(sample_acc) * 10 + longint'(ch - ChZero);
              if (wide > SampleMax) raise_error();
              else sample_acc = NumBits'(wide);
            end
          end else begin
            raise_error();
          end
        end
        default: ;
      endcase
    end
    n = step_results.size();
    for (int i = 0; i < n; i++) begin
      r = step_results[i];
      r.final_item = (i == n - 1);
      results_due.insert(results_due.size(), r);
    end
  endfunction

  function automatic string show(result_t r);
    return $sformatf("kind %0d sample %0d width %0d height %0d maxval %0d last %0b",
                     r.kind, r.sample, r.img_width, r.img_height, r.max_level,
                     r.final_item);
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got.kind       = m_tuser_i;
    got.sample     = m_tdata_i[15:0];
    got.img_width  = m_tdata_i[31:16];
    got.img_height = m_tdata_i[47:32];
    got.max_level  = m_tdata_i[63:48];
    got.final_item = m_tlast_i;
    n_checked++;
    if (results_due.size() == 0) begin
      if (n_mismatch < 10) $display("%0t: result with nothing pending: %s", $realtime, show(got));
      n_mismatch++;
    end else begin
      want = results_due.pop_front();
      if (got.kind !== want.kind || got.sample !== want.sample ||
          got.img_width !== want.img_width || got.img_height !== want.img_height ||
          got.max_level !== want.max_level || got.final_item !== want.final_item) begin
        if (n_mismatch < 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        n_mismatch++;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_state();
      results_due.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) predict_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_result();
    end
    n_pending = results_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the PPM stream parser testbench: clock, reset, byte-file stimulus
// and the receiver's back-pressure. Depends on ppmp_pkg, the parser top
// ascii_ppm_stream_parser and ppm_result_checker, which does the checking.

module tb_top;

  import ppmp_pkg::*;

  typedef enum int {
    FaultNone,
    FaultMagic,
    FaultThirdToken,
    FaultZeroDim,
    FaultEmptySize,
    FaultHdrOverflow,
    FaultMaxvToken,
    FaultPixelChar,
    FaultSampleOverflow,
    FaultCountOff,
    FaultTruncate,
    FaultNoise
  } fault_e;

  localparam int RandomBytesPerPhase = 550;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        hold_rx  = 1'b0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  int          bytes_sent    = 0;
  int          files_sent    = 0;
  logic [7:0]  file_bytes[$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ascii_ppm_stream_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  ppm_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    m_tready <= !hold_rx && ($urandom_range(99) >= sink_idle_pct);
  end

  // A long receiver stall while the sender keeps going fills the result queue.
  initial begin
    wait (bytes_sent >= 500);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending.", pending);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_byte(input logic [7:0] ch, input logic eof);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eof;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], 1'b0);
    send_byte(8'($urandom), 1'b1);
    files_sent++;
  endtask

  function automatic void add_byte(logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_num(int unsigned v);
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void add_spaces(int unsigned n);
    repeat (n) add_byte(ChSpace);
  endfunction

  function automatic logic [7:0] comment_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ChNewline);
    return b;
  endfunction

  function automatic logic [7:0] bad_pixel_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == ChNewline || b == ChSpace || (b >= ChZero && b <= ChNine));
    return b;
  endfunction

  function automatic void add_separator();
    case ($urandom_range(4))
      0:       add_byte(ChNewline);
      1:       add_text("  ");
      2:       add_text(" \n");
      3:       add_text("\n\n ");
      default: add_byte(ChSpace);
    endcase
  endfunction

  // Mostly well-formed files with small images; the rest carry one fault.
  function automatic void build_file();
    fault_e      fault;
    int unsigned w;
    int unsigned h;
    int unsigned mv;
    int unsigned top;
    int unsigned n_samp;
    int unsigned bad_at;
    int unsigned cut;
    file_bytes.delete();
    if ($urandom_range(99) < 70) fault = FaultNone;
    else fault = fault_e'($urandom_range(int'(FaultMagic), int'(FaultNoise)));

    if (fault == FaultNoise) begin
      repeat ($urandom_range(1, 20)) begin
        case ($urandom_range(3))
          0:       add_byte(ChNewline);
          1:       add_byte(ChP);
          2:       add_byte(ChThree);
          default: add_byte(8'($urandom));
        endcase
      end
      return;
    end

    if (fault == FaultMagic) begin
      case ($urandom_range(4))
        0:       add_text("P3\r\n");
        1:       add_text("P6\n");
        2:       add_text("P33\n");
        3:       add_text("\n");
        default: begin
          add_byte(8'($urandom));
          add_text("3\n");
        end
      endcase
    end else begin
      add_text("P3\n");
    end

    repeat ($urandom_range(0, 2)) begin
      add_byte(ChHash);
      repeat ($urandom_range(0, 6)) add_byte(comment_byte());
      add_byte(ChNewline);
    end

    w = $urandom_range(1, 3);
    h = $urandom_range(1, 3);
    if ($urandom_range(19) == 0) begin
      w = 65535;
      h = $urandom_range(1, 65535);
    end
    case ($urandom_range(3))
      0:       mv = 255;
      1:       mv = 0;
      2:       mv = 65535;
      default: mv = $urandom_range(1, 65535);
    endcase
    if (fault == FaultZeroDim) begin
      if ($urandom_range(1)) w = 0;
      else h = 0;
    end
    if (fault == FaultHdrOverflow) begin
      case ($urandom_range(2))
        0:       w = $urandom_range(65536, 99999);
        1:       h = $urandom_range(65536, 99999);
        default: mv = $urandom_range(65536, 99999);
      endcase
    end

    if (fault == FaultEmptySize) begin
      add_byte(ChNewline);
    end else begin
      add_spaces($urandom_range(0, 2));
      add_num(w);
      if ($urandom_range(9) == 0) add_byte(8'h09);
      add_spaces($urandom_range(1, 2));
      add_num(h);
      if (fault == FaultThirdToken) begin
        add_byte(ChSpace);
        add_num($urandom_range(0, 99));
      end else begin
        add_spaces($urandom_range(0, 1));
      end
      add_byte(ChNewline);
    end

    add_spaces($urandom_range(0, 1));
    add_num(mv);
    if (fault == FaultMaxvToken) begin
      add_byte(ChSpace);
      add_num($urandom_range(0, 999));
    end else begin
      add_spaces($urandom_range(0, 1));
    end
    add_byte(ChNewline);

    top    = (mv > 65535) ? 65535 : mv;
    n_samp = (w * h <= 9) ? w * h * 3 : $urandom_range(0, 4);
    if (fault == FaultCountOff) begin
      if (n_samp == 0 || $urandom_range(1)) n_samp++;
      else n_samp--;
    end
    bad_at = $urandom_range(0, (n_samp == 0) ? 0 : n_samp - 1);
    for (int unsigned i = 0; i < n_samp; i++) begin
      if (i > 0) add_separator();
      if (i == bad_at && fault == FaultPixelChar) add_byte(bad_pixel_byte());
      if (i == bad_at && fault == FaultSampleOverflow) begin
        add_num($urandom_range(65536, 999999));
        add_byte(ChSpace);
      end
      case ($urandom_range(5))
        0:       add_num(0);
        1:       add_num(65535);
        default: add_num($urandom_range(0, top));
      endcase
    end
    if ($urandom_range(1)) add_byte(ChNewline);

    if (fault == FaultTruncate) begin
      cut = $urandom_range(0, file_bytes.size() - 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A minimal image with a comment and a zero maxval, then a broken magic
    // line made of the extreme byte values that ends at end of file.
    file_bytes.delete();
    add_text("P3\n#\n1 1\n0\n0 0 0\n");
    send_file();
    file_bytes.delete();
    add_byte(8'hFF);
    add_byte(8'h00);
    send_file();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 16;
          sink_idle_pct <= 49;
        end
        1: begin
          src_idle_pct  = 49;
          sink_idle_pct <= 16;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct <= 0;
        end
      endcase
      while (bytes_sent < 25 + (ph + 1) * RandomBytesPerPhase) begin
        build_file();
        send_file();
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Parsed %0d files in %0d bytes, including a 400-cycle receiver stall.",
             files_sent, bytes_sent);
    $display("Checked %0d results: %0d mismatched, %0d never arrived.",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
